@@ src/dnsa_pkg.sv @@
`timescale 1ns / 1ps

package dnsa_pkg;

    // Result codes reported on the last byte of a message.
    typedef enum logic [2:0] {
        ST_FOUND       = 3'd0,
        ST_TRUNCATED   = 3'd1,
        ST_ID_MISMATCH = 3'd2,
        ST_NOT_RESP    = 3'd3,
        ST_RCODE_ERR   = 3'd4,
        ST_NO_ANSWERS  = 3'd5,
        ST_RSV_PREFIX  = 3'd6,
        ST_NO_A_RECORD = 3'd7
    } status_t;

    // One result word as it leaves the parser.
    typedef struct packed {
        status_t     status;
        logic [31:0] address;
    } result_t;

    // Fixed field lengths, in bytes.
    localparam logic [3:0] HDR_LEN       = 4'd12;
    localparam logic [3:0] Q_FIXED_LEN   = 4'd4;
    localparam logic [3:0] A_FIXED_LEN   = 4'd10;

    // Record matching: type A, class IN, four bytes of data.
    localparam logic [15:0] TYPE_A       = 16'h0001;
    localparam logic [15:0] CLASS_IN     = 16'h0001;
    localparam logic [15:0] A_DATA_LEN   = 16'h0004;

    // Top two bits of a name length byte.
    localparam logic [1:0]  PREFIX_PTR   = 2'b11;
    localparam logic [1:0]  PREFIX_LABEL = 2'b00;

endpackage

@@ src/dnsa_parser.sv @@
`timescale 1ns / 1ps

module dnsa_parser #(
    parameter int MAX_MESSAGE = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_valid,
    input  logic [7:0]        step_byte,
    input  logic              step_last,
    input  logic [15:0]       expected_id,
    output dnsa_pkg::result_t result
);

    localparam int CW = $clog2(MAX_MESSAGE + 1);

    typedef enum logic [3:0] {
        PH_HDR     = 4'd0,
        PH_Q_LEN   = 4'd1,
        PH_Q_LABEL = 4'd2,
        PH_Q_PTR   = 4'd3,
        PH_Q_FIXED = 4'd4,
        PH_A_LEN   = 4'd5,
        PH_A_LABEL = 4'd6,
        PH_A_PTR   = 4'd7,
        PH_A_FIXED = 4'd8,
        PH_A_DATA  = 4'd9,
        PH_A_SKIP  = 4'd10
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [3:0]          fbc_reg, fbc_next;
    logic                resp_reg, resp_next;
    logic [15:0]         q_left_reg, q_left_next;
    logic [15:0]         a_left_reg, a_left_next;
    logic [5:0]          label_reg, label_next;
    logic [15:0]         rtype_reg, rtype_next;
    logic [15:0]         rclass_reg, rclass_next;
    logic [15:0]         d_left_reg, d_left_next;
    logic [31:0]         accum_reg, accum_next;
    dnsa_pkg::status_t   status_reg, status_next;
    logic                decided_reg, decided_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                id_bad_reg, id_bad_next;
    logic                rcode_bad_reg, rcode_bad_next;

    logic [3:0]          k_inc;
    dnsa_pkg::status_t   res_status;

    // Next-state logic: one byte through the parser, then the end-of-message check.
    always_comb
    begin
        phase_next     = phase_reg;
        fbc_next       = fbc_reg;
        resp_next      = resp_reg;
        q_left_next    = q_left_reg;
        a_left_next    = a_left_reg;
        label_next     = label_reg;
        rtype_next     = rtype_reg;
        rclass_next    = rclass_reg;
        d_left_next    = d_left_reg;
        accum_next     = accum_reg;
        status_next    = status_reg;
        decided_next   = decided_reg;
        count_next     = count_reg;
        id_bad_next    = id_bad_reg;
        rcode_bad_next = rcode_bad_reg;
        k_inc          = fbc_reg + 4'd1;
        res_status     = dnsa_pkg::ST_TRUNCATED;

        // Bytes past the receive buffer size are dropped.
        if (step_valid && (count_reg < CW'(MAX_MESSAGE)))
        begin
            count_next = count_reg + CW'(1);
            if (!decided_reg)
            begin
                unique case (phase_reg) inside
                    PH_HDR:
                    begin
                        if (fbc_reg == 4'd0 && step_byte != expected_id[15:8])
                            id_bad_next = 1'b1;
                        if (fbc_reg == 4'd1 && step_byte != expected_id[7:0])
                            id_bad_next = 1'b1;
                        if (fbc_reg == 4'd2)
                            resp_next = step_byte[7];
                        if (fbc_reg == 4'd3)
                            rcode_bad_next = (step_byte[3:0] != 4'd0);
                        if (fbc_reg == 4'd4)
                            q_left_next = {step_byte, 8'h00};
                        if (fbc_reg == 4'd5)
                            q_left_next = {q_left_reg[15:8], step_byte};
                        if (fbc_reg == 4'd6)
                            a_left_next = {step_byte, 8'h00};
                        if (fbc_reg == 4'd7)
                            a_left_next = {a_left_reg[15:8], step_byte};
                        fbc_next = k_inc;
                        // Header complete: judge it in priority order.
                        if (k_inc == dnsa_pkg::HDR_LEN)
                        begin
                            fbc_next = 4'd0;
                            if (id_bad_reg)
                            begin
                                status_next  = dnsa_pkg::ST_ID_MISMATCH;
                                decided_next = 1'b1;
                            end
                            else if (!resp_reg)
                            begin
                                status_next  = dnsa_pkg::ST_NOT_RESP;
                                decided_next = 1'b1;
                            end
                            else if (rcode_bad_reg)
                            begin
                                status_next  = dnsa_pkg::ST_RCODE_ERR;
                                decided_next = 1'b1;
                            end
                            else if (a_left_reg == 16'd0)
                            begin
                                status_next  = dnsa_pkg::ST_NO_ANSWERS;
                                decided_next = 1'b1;
                            end
                            else if (q_left_reg != 16'd0)
                                phase_next = PH_Q_LEN;
                            else
                                phase_next = PH_A_LEN;
                        end
                    end
                    PH_Q_LEN, PH_A_LEN:
                    begin
                        // A pointer ends the name; a zero length ends it too.
                        if (step_byte[7:6] == dnsa_pkg::PREFIX_PTR)
                            phase_next = (phase_reg == PH_Q_LEN) ? PH_Q_PTR : PH_A_PTR;
                        else if (step_byte == 8'd0)
                        begin
                            phase_next = (phase_reg == PH_Q_LEN) ? PH_Q_FIXED : PH_A_FIXED;
                            fbc_next   = 4'd0;
                        end
                        else if (step_byte[7:6] != dnsa_pkg::PREFIX_LABEL)
                        begin
                            status_next  = dnsa_pkg::ST_RSV_PREFIX;
                            decided_next = 1'b1;
                        end
                        else
                        begin
                            label_next = step_byte[5:0];
                            phase_next = (phase_reg == PH_Q_LEN) ? PH_Q_LABEL : PH_A_LABEL;
                        end
                    end
                    PH_Q_LABEL, PH_A_LABEL:
                    begin
                        label_next = label_reg - 6'd1;
                        if (label_next == 6'd0)
                            phase_next = (phase_reg == PH_Q_LABEL) ? PH_Q_LEN : PH_A_LEN;
                    end
                    PH_Q_PTR, PH_A_PTR:
                    begin
                        // Second pointer byte is not followed.
                        phase_next = (phase_reg == PH_Q_PTR) ? PH_Q_FIXED : PH_A_FIXED;
                        fbc_next   = 4'd0;
                    end
                    PH_Q_FIXED:
                    begin
                        fbc_next = k_inc;
                        if (k_inc == dnsa_pkg::Q_FIXED_LEN)
                        begin
                            fbc_next    = 4'd0;
                            q_left_next = q_left_reg - 16'd1;
                            phase_next  = (q_left_next != 16'd0) ? PH_Q_LEN : PH_A_LEN;
                        end
                    end
                    PH_A_FIXED:
                    begin
                        if (fbc_reg == 4'd0)
                            rtype_next = {step_byte, 8'h00};
                        if (fbc_reg == 4'd1)
                            rtype_next = {rtype_reg[15:8], step_byte};
                        if (fbc_reg == 4'd2)
                            rclass_next = {step_byte, 8'h00};
                        if (fbc_reg == 4'd3)
                            rclass_next = {rclass_reg[15:8], step_byte};
                        if (fbc_reg == 4'd8)
                            d_left_next = {step_byte, 8'h00};
                        if (fbc_reg == 4'd9)
                            d_left_next = {d_left_reg[15:8], step_byte};
                        fbc_next = k_inc;
                        if (k_inc == dnsa_pkg::A_FIXED_LEN)
                        begin
                            fbc_next = 4'd0;
                            if (rtype_next == dnsa_pkg::TYPE_A &&
                                rclass_next == dnsa_pkg::CLASS_IN &&
                                d_left_next == dnsa_pkg::A_DATA_LEN)
                            begin
                                accum_next = 32'd0;
                                phase_next = PH_A_DATA;
                            end
                            else if (d_left_next == 16'd0)
                            begin
                                a_left_next = a_left_reg - 16'd1;
                                if (a_left_next == 16'd0)
                                begin
                                    status_next  = dnsa_pkg::ST_NO_A_RECORD;
                                    decided_next = 1'b1;
                                end
                                else
                                    phase_next = PH_A_LEN;
                            end
                            else
                                phase_next = PH_A_SKIP;
                        end
                    end
                    PH_A_DATA:
                    begin
                        accum_next  = {accum_reg[23:0], step_byte};
                        d_left_next = d_left_reg - 16'd1;
                        if (d_left_next == 16'd0)
                        begin
                            status_next  = dnsa_pkg::ST_FOUND;
                            decided_next = 1'b1;
                        end
                    end
                    PH_A_SKIP:
                    begin
                        d_left_next = d_left_reg - 16'd1;
                        if (d_left_next == 16'd0)
                        begin
                            a_left_next = a_left_reg - 16'd1;
                            if (a_left_next == 16'd0)
                            begin
                                status_next  = dnsa_pkg::ST_NO_A_RECORD;
                                decided_next = 1'b1;
                            end
                            else
                                phase_next = PH_A_LEN;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // End of message: report, then return to the start of a message.
        if (decided_next)
            res_status = status_next;
        if (step_valid && step_last)
        begin
            phase_next     = PH_HDR;
            fbc_next       = 4'd0;
            resp_next      = 1'b0;
            q_left_next    = 16'd0;
            a_left_next    = 16'd0;
            label_next     = 6'd0;
            rtype_next     = 16'd0;
            rclass_next    = 16'd0;
            d_left_next    = 16'd0;
            status_next    = dnsa_pkg::ST_FOUND;
            decided_next   = 1'b0;
            count_next     = '0;
            id_bad_next    = 1'b0;
            rcode_bad_next = 1'b0;
        end
    end

    assign result.status  = res_status;
    assign result.address = (res_status == dnsa_pkg::ST_FOUND) ? accum_next : 32'd0;

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR;
            fbc_reg       <= 4'd0;
            resp_reg      <= 1'b0;
            q_left_reg    <= 16'd0;
            a_left_reg    <= 16'd0;
            label_reg     <= 6'd0;
            rtype_reg     <= 16'd0;
            rclass_reg    <= 16'd0;
            d_left_reg    <= 16'd0;
            accum_reg     <= 32'd0;
            status_reg    <= dnsa_pkg::ST_FOUND;
            decided_reg   <= 1'b0;
            count_reg     <= '0;
            id_bad_reg    <= 1'b0;
            rcode_bad_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            fbc_reg       <= fbc_next;
            resp_reg      <= resp_next;
            q_left_reg    <= q_left_next;
            a_left_reg    <= a_left_next;
            label_reg     <= label_next;
            rtype_reg     <= rtype_next;
            rclass_reg    <= rclass_next;
            d_left_reg    <= d_left_next;
            accum_reg     <= (step_valid && step_last) ? 32'd0 : accum_next;
            status_reg    <= status_next;
            decided_reg   <= decided_next;
            count_reg     <= count_next;
            id_bad_reg    <= id_bad_next;
            rcode_bad_reg <= rcode_bad_next;
        end
    end

endmodule

@@ src/dns_a_answer_parser.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Word
// s_axis    in         tdata = data_byte, tlast = last_byte
// m_axis    out        tdata = status, address (one word per message)
// cfg       in         cfg_wr_data = expected_id
//
// Takes one byte per cycle while no last byte is held back; a message's result is
// loaded into the result register as its last byte leaves the input register. The
// rate is set by the parser state update between the input and result registers.
// Reset clears all parser state, the result valid flag and expected_id.
// A waiting result stalls only a following last byte in the input register;
// other bytes keep flowing.

module dns_a_answer_parser #(
    parameter int MAX_MESSAGE = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [2:0] status, [34:3] address, [39:35] zero
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              in_advance;
    logic              out_load;
    logic              out_valid_reg;
    dnsa_pkg::result_t out_result_reg;
    dnsa_pkg::result_t step_result;
    logic [15:0]       expected_id_reg;

    // A word moves on unless it ends a message and a full result slot is not taken.
    assign in_advance    = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || in_advance;
    assign out_load      = in_advance && in_last_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expected_id_reg <= 16'd0;
        else if (cfg_wr_en)
            expected_id_reg <= cfg_wr_data;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    dnsa_parser #(
        .MAX_MESSAGE(MAX_MESSAGE)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (in_advance),
        .step_byte  (in_byte_reg),
        .step_last  (in_last_reg),
        .expected_id(expected_id_reg),
        .result     (step_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_result_reg <= step_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_result_reg.address, out_result_reg.status};

`ifndef SYNTHESIS
    // A result is only loaded into a free or draining slot.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("result register overwritten");

    // A stalled input word stays in the input register unchanged.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !in_advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input register lost a word");

    // The address is zero unless an A record was found.
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_result_reg.status != dnsa_pkg::ST_FOUND)
            |-> (out_result_reg.address == 32'd0))
        else $error("address set without a found record");
`endif

endmodule

@@ tb/dns_a_answer_parser_test.sv @@
`timescale 1ns / 1ps

module dns_a_answer_parser_test;

    localparam int MAX_MSG = 512;

    // Parser position inside a reply, mirrored for the predictor.
    typedef enum logic [3:0] {
        P_HDR,
        P_QLEN,
        P_QLABEL,
        P_QPTR,
        P_QFIXED,
        P_ALEN,
        P_ALABEL,
        P_APTR,
        P_AFIXED,
        P_ADATA,
        P_ASKIP
    } parse_pos_t;

    typedef struct {
        dnsa_pkg::status_t status;
        logic [31:0]       address;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [2:0] status, [34:3] address, [39:35] zero
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;

    // Predictor state for the message in flight.
    logic [15:0]       txn_id;
    parse_pos_t        pos;
    logic [3:0]        fcnt;
    logic [7:0]        flags_hi;
    logic [15:0]       qd_left;
    logic [15:0]       an_left;
    logic [5:0]        lbl_left;
    logic [15:0]       rr_type;
    logic [15:0]       rr_class;
    logic [15:0]       rd_left;
    logic [31:0]       addr_acc;
    dnsa_pkg::status_t verdict;
    logic              have_verdict;
    int                msg_len;
    logic              id_mismatch;
    logic              rcode_nonzero;

    reply_t      pending_replies[$];
    reply_t      oldest_reply;
    logic [7:0]  reply_bytes[$];
    int          failures = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          random_bytes = 0;

    dns_a_answer_parser #(
        .MAX_MESSAGE(MAX_MSG)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // Clear everything that belongs to one message.
    function automatic void clear_parse();
        pos = P_HDR;
        fcnt = 4'd0;
        flags_hi = 8'h00;
        qd_left = 16'h0000;
        an_left = 16'h0000;
        lbl_left = 6'd0;
        rr_type = 16'h0000;
        rr_class = 16'h0000;
        rd_left = 16'h0000;
        addr_acc = 32'h0;
        verdict = dnsa_pkg::ST_FOUND;
        have_verdict = 1'b0;
        msg_len = 0;
        id_mismatch = 1'b0;
        rcode_nonzero = 1'b0;
    endfunction

    // Only the first verdict of a message counts.
    function automatic void settle_on(input dnsa_pkg::status_t st);
        if (!have_verdict)
        begin
            verdict = st;
            have_verdict = 1'b1;
        end
    endfunction

    function automatic void finish_answer();
        an_left = an_left - 16'd1;
        if (an_left == 16'd0)
            settle_on(dnsa_pkg::ST_NO_A_RECORD);
        else
            pos = P_ALEN;
    endfunction

    // Length byte of a name in the question or the answer section.
    function automatic void name_len_byte(input logic [7:0] b, input logic in_answer);
        if (b[7:6] == dnsa_pkg::PREFIX_PTR)
            pos = in_answer ? P_APTR : P_QPTR;
        else if (b == 8'h00)
        begin
            pos = in_answer ? P_AFIXED : P_QFIXED;
            fcnt = 4'd0;
        end
        else if (b[7:6] != dnsa_pkg::PREFIX_LABEL)
            settle_on(dnsa_pkg::ST_RSV_PREFIX);
        else
        begin
            lbl_left = b[5:0];
            pos = in_answer ? P_ALABEL : P_QLABEL;
        end
    endfunction

    function automatic void parse_reply_byte(input logic [7:0] b);
        logic [3:0] k;
        k = fcnt;
        case (pos) inside
            P_HDR:
            begin
                if (k == 4'd0 && b != txn_id[15:8])
                    id_mismatch = 1'b1;
                if (k == 4'd1 && b != txn_id[7:0])
                    id_mismatch = 1'b1;
                if (k == 4'd2)
                    flags_hi = b;
                if (k == 4'd3)
                    rcode_nonzero = (b[3:0] != 4'h0);
                if (k == 4'd4)
                    qd_left = {b, 8'h00};
                if (k == 4'd5)
                    qd_left[7:0] = b;
                if (k == 4'd6)
                    an_left = {b, 8'h00};
                if (k == 4'd7)
                    an_left[7:0] = b;
                k = k + 4'd1;
                fcnt = k;
                if (k == dnsa_pkg::HDR_LEN)
                begin
                    fcnt = 4'd0;
                    if (id_mismatch)
                        settle_on(dnsa_pkg::ST_ID_MISMATCH);
                    else if (!flags_hi[7])
                        settle_on(dnsa_pkg::ST_NOT_RESP);
                    else if (rcode_nonzero)
                        settle_on(dnsa_pkg::ST_RCODE_ERR);
                    else if (an_left == 16'd0)
                        settle_on(dnsa_pkg::ST_NO_ANSWERS);
                    else
                        pos = (qd_left != 16'd0) ? P_QLEN : P_ALEN;
                end
            end
            P_QLEN:   name_len_byte(b, 1'b0);
            P_ALEN:   name_len_byte(b, 1'b1);
            P_QLABEL, P_ALABEL:
            begin
                lbl_left = lbl_left - 6'd1;
                if (lbl_left == 6'd0)
                    pos = (pos == P_QLABEL) ? P_QLEN : P_ALEN;
            end
            P_QPTR:
            begin
                pos = P_QFIXED;
                fcnt = 4'd0;
            end
            P_APTR:
            begin
                pos = P_AFIXED;
                fcnt = 4'd0;
            end
            P_QFIXED:
            begin
                k = k + 4'd1;
                fcnt = k;
                if (k == dnsa_pkg::Q_FIXED_LEN)
                begin
                    fcnt = 4'd0;
                    qd_left = qd_left - 16'd1;
                    pos = (qd_left != 16'd0) ? P_QLEN : P_ALEN;
                end
            end
            P_AFIXED:
            begin
                if (k == 4'd0)
                    rr_type = {b, 8'h00};
                if (k == 4'd1)
                    rr_type[7:0] = b;
                if (k == 4'd2)
                    rr_class = {b, 8'h00};
                if (k == 4'd3)
                    rr_class[7:0] = b;
                if (k == 4'd8)
                    rd_left = {b, 8'h00};
                if (k == 4'd9)
                    rd_left[7:0] = b;
                k = k + 4'd1;
                fcnt = k;
                if (k == dnsa_pkg::A_FIXED_LEN)
                begin
                    fcnt = 4'd0;
                    if (rr_type == dnsa_pkg::TYPE_A && rr_class == dnsa_pkg::CLASS_IN &&
                        rd_left == dnsa_pkg::A_DATA_LEN)
                    begin
                        addr_acc = 32'h0;
                        pos = P_ADATA;
                    end
                    else if (rd_left == 16'd0)
                        finish_answer();
                    else
                        pos = P_ASKIP;
                end
            end
            P_ADATA:
            begin
                addr_acc = {addr_acc[23:0], b};
                rd_left = rd_left - 16'd1;
                if (rd_left == 16'd0)
                    settle_on(dnsa_pkg::ST_FOUND);
            end
            P_ASKIP:
            begin
                rd_left = rd_left - 16'd1;
                if (rd_left == 16'd0)
                    finish_answer();
            end
            default: ;
        endcase
    endfunction

    // One accepted byte: bytes past the buffer size are dropped, the last one closes the reply.
    function automatic void predict_byte(input logic [7:0] b, input logic last);
        reply_t r;
        if (msg_len < MAX_MSG)
        begin
            msg_len++;
            if (!have_verdict)
                parse_reply_byte(b);
        end
        if (last)
        begin
            settle_on(dnsa_pkg::ST_TRUNCATED);
            r.status = verdict;
            r.address = (verdict == dnsa_pkg::ST_FOUND) ? addr_acc : 32'h0;
            pending_replies.push_back(r);
            clear_parse();
        end
    endfunction

    // Message building helpers.
    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(255));
    endfunction

    function automatic void put16(input logic [15:0] v);
        reply_bytes.push_back(v[15:8]);
        reply_bytes.push_back(v[7:0]);
    endfunction

    function automatic void put_header(input logic [15:0] id, input logic [15:0] flags,
                                       input logic [15:0] qd, input logic [15:0] an);
        put16(id);
        put16(flags);
        put16(qd);
        put16(an);
        repeat (4)
            reply_bytes.push_back(rnd8());
    endfunction

    function automatic void put_label(input int len);
        reply_bytes.push_back(8'(len));
        repeat (len)
            reply_bytes.push_back(rnd8());
    endfunction

    function automatic void put_name(input bit may_break);
        int         labels;
        logic [5:0] low6;
        labels = $urandom_range(2);
        low6 = 6'($urandom_range(63));
        repeat (labels)
        begin
            if (may_break && $urandom_range(39) == 0)
                reply_bytes.push_back(8'($urandom_range(8'h40, 8'hBF)));
            put_label($urandom_range(1, 6));
        end
        if ($urandom_range(1) == 1)
        begin
            reply_bytes.push_back({dnsa_pkg::PREFIX_PTR, low6});
            reply_bytes.push_back(rnd8());
        end
        else
            reply_bytes.push_back(8'h00);
    endfunction

    function automatic void put_question(input bit may_break);
        put_name(may_break);
        repeat (4)
            reply_bytes.push_back(rnd8());
    endfunction

    function automatic void put_record(input logic [15:0] rtype, input logic [15:0] rclass,
                                       input logic [15:0] rdlen, input bit may_break);
        put_name(may_break);
        put16(rtype);
        put16(rclass);
        repeat (4)
            reply_bytes.push_back(rnd8());
        put16(rdlen);
        repeat (rdlen)
            reply_bytes.push_back(rnd8());
    endfunction

    // Drive one word on the input stream and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_byte(b, last);
    endtask

    task automatic send_reply();
        for (int i = 0; i < reply_bytes.size(); i++)
            send_byte(reply_bytes[i], i == reply_bytes.size() - 1);
        reply_bytes.delete();
    endtask

    // Wait until every expected reply has come out, then let the pipeline empty.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic set_txn_id(input logic [15:0] id);
        drain();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= id;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        txn_id = id;
    endtask

    // Header checks, each failure in its order of priority.
    task automatic test_header_checks();
        set_txn_id(16'h0000);
        reply_bytes.push_back(8'h00);
        send_reply();
        put_header(16'h0000, 16'h8180, 16'h0000, 16'h0001);
        reply_bytes = reply_bytes[0:10];
        send_reply();
        put_header(16'h0100, 16'h8180, 16'h0000, 16'h0001);
        send_reply();
        put_header(16'h0001, 16'h8180, 16'h0000, 16'h0001);
        send_reply();
        put_header(16'h00FF, 16'h000F, 16'h0000, 16'h0000);
        send_reply();
        put_header(16'h0000, 16'h000F, 16'h0000, 16'h0001);
        send_reply();
        put_header(16'h0000, 16'h8001, 16'h0000, 16'h0001);
        send_reply();
        put_header(16'h0000, 16'h8180, 16'h0001, 16'h0000);
        send_reply();
        // Upper flag bits other than the response bit do not matter.
        put_header(16'h0000, 16'hFFF0, 16'h0000, 16'h0001);
        put_record(dnsa_pkg::TYPE_A, dnsa_pkg::CLASS_IN, dnsa_pkg::A_DATA_LEN, 1'b0);
        send_reply();
        set_txn_id(16'hFFFF);
        put_header(16'hFFFF, 16'h8180, 16'hFFFF, 16'h0000);
        send_reply();
        put_header(16'hFFFE, 16'h8180, 16'h0000, 16'h0001);
        send_reply();
    endtask

    // Answer walking: skipped records, rejected records and the found address.
    task automatic test_record_walk();
        set_txn_id(16'($urandom_range(16'hFFFF)));
        put_header(txn_id, 16'h8180, 16'h0001, 16'h0001);
        put_question(1'b0);
        put_record(dnsa_pkg::TYPE_A, dnsa_pkg::CLASS_IN, dnsa_pkg::A_DATA_LEN, 1'b0);
        send_reply();
        put_header(txn_id, 16'h8180, 16'h0000, 16'hFFFF);
        put_record(dnsa_pkg::TYPE_A, dnsa_pkg::CLASS_IN, dnsa_pkg::A_DATA_LEN, 1'b0);
        send_reply();
        put_header(txn_id, 16'h8180, 16'h0001, 16'h0002);
        put_question(1'b0);
        put_record(16'h0005, dnsa_pkg::CLASS_IN, 16'h0003, 1'b0);
        put_record(dnsa_pkg::TYPE_A, dnsa_pkg::CLASS_IN, dnsa_pkg::A_DATA_LEN, 1'b0);
        send_reply();
        put_header(txn_id, 16'h8180, 16'h0000, 16'h0001);
        put_record(dnsa_pkg::TYPE_A, 16'h0002, dnsa_pkg::A_DATA_LEN, 1'b0);
        send_reply();
        put_header(txn_id, 16'h8180, 16'h0000, 16'h0001);
        put_record(dnsa_pkg::TYPE_A, dnsa_pkg::CLASS_IN, 16'h0000, 1'b0);
        send_reply();
        put_header(txn_id, 16'h8180, 16'h0000, 16'h0001);
        put_record(dnsa_pkg::TYPE_A, dnsa_pkg::CLASS_IN, 16'h0005, 1'b0);
        send_reply();
        put_header(txn_id, 16'h8180, 16'h0000, 16'h0002);
        put_record(16'hFFFF, 16'hFFFF, 16'h0011, 1'b0);
        put_record(dnsa_pkg::TYPE_A, dnsa_pkg::CLASS_IN, dnsa_pkg::A_DATA_LEN, 1'b0);
        send_reply();
        // Message ends inside the address.
        put_header(txn_id, 16'h8180, 16'h0000, 16'h0001);
        put_record(dnsa_pkg::TYPE_A, dnsa_pkg::CLASS_IN, dnsa_pkg::A_DATA_LEN, 1'b0);
        reply_bytes = reply_bytes[0:reply_bytes.size() - 3];
        send_reply();
        // Bytes after the verdict are ignored.
        put_header(txn_id, 16'h8180, 16'h0000, 16'h0001);
        put_record(dnsa_pkg::TYPE_A, dnsa_pkg::CLASS_IN, dnsa_pkg::A_DATA_LEN, 1'b0);
        repeat (6)
            reply_bytes.push_back(rnd8());
        send_reply();
    endtask

    // Name skipping: longest label, pointers, reserved prefixes.
    task automatic test_name_skipping();
        put_header(txn_id, 16'h8180, 16'h0001, 16'h0001);
        put_label(63);
        reply_bytes.push_back(8'h00);
        repeat (4)
            reply_bytes.push_back(rnd8());
        reply_bytes.push_back(8'hC0);
        reply_bytes.push_back(8'h0C);
        put16(dnsa_pkg::TYPE_A);
        put16(dnsa_pkg::CLASS_IN);
        repeat (4)
            reply_bytes.push_back(8'hFF);
        put16(dnsa_pkg::A_DATA_LEN);
        repeat (4)
            reply_bytes.push_back(rnd8());
        send_reply();
        put_header(txn_id, 16'h8180, 16'h0001, 16'h0001);
        put_label(3);
        reply_bytes.push_back(8'h40);
        repeat (8)
            reply_bytes.push_back(rnd8());
        send_reply();
        put_header(txn_id, 16'h8180, 16'h0000, 16'h0001);
        reply_bytes.push_back(8'hBF);
        repeat (8)
            reply_bytes.push_back(rnd8());
        send_reply();
        put_header(txn_id, 16'h8180, 16'h0001, 16'h0001);
        reply_bytes.push_back(8'hFF);
        reply_bytes.push_back(8'hFF);
        repeat (4)
            reply_bytes.push_back(rnd8());
        put_record(dnsa_pkg::TYPE_A, dnsa_pkg::CLASS_IN, dnsa_pkg::A_DATA_LEN, 1'b0);
        send_reply();
        // Many questions announced, message ends early.
        put_header(txn_id, 16'h8180, 16'hFFFF, 16'h0001);
        put_question(1'b0);
        put_question(1'b0);
        send_reply();
    endtask

    // Receive buffer size: the address ends on the last kept byte and the
    // closing byte after it is dropped. The long skipped record also crosses
    // the upper byte of the data length.
    task automatic test_message_limits();
        put_header(txn_id, 16'h8180, 16'h0000, 16'h0002);
        reply_bytes.push_back(8'hC0);
        reply_bytes.push_back(8'h0C);
        put16(16'h0010);
        put16(dnsa_pkg::CLASS_IN);
        repeat (4)
            reply_bytes.push_back(rnd8());
        put16(16'h01D8);
        repeat (472)
            reply_bytes.push_back(rnd8());
        reply_bytes.push_back(8'hC0);
        reply_bytes.push_back(8'h0C);
        put16(dnsa_pkg::TYPE_A);
        put16(dnsa_pkg::CLASS_IN);
        repeat (4)
            reply_bytes.push_back(rnd8());
        put16(dnsa_pkg::A_DATA_LEN);
        repeat (4)
            reply_bytes.push_back(rnd8());
        reply_bytes.push_back(rnd8());
        send_reply();
    endtask

    // One random reply: mostly well formed, some broken, some plain noise.
    task automatic random_reply();
        int          kind;
        int          an;
        int          pick;
        logic [15:0] id;
        logic [15:0] flags;
        kind = $urandom_range(99);
        id = ($urandom_range(9) == 0) ? 16'($urandom_range(16'hFFFF)) : txn_id;
        flags = 16'($urandom_range(16'hFFFF));
        flags[15] = ($urandom_range(19) != 0);
        if ($urandom_range(9) != 0)
            flags[3:0] = 4'h0;
        an = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 3);
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 40))
                reply_bytes.push_back(rnd8());
        end
        else
        begin
            put_header(id, flags, 16'($urandom_range(2)), 16'(an));
            repeat (reply_bytes[5])
                put_question(1'b1);
            repeat (an)
            begin
                pick = $urandom_range(9);
                case (pick) inside
                    [0:3]: put_record(dnsa_pkg::TYPE_A, dnsa_pkg::CLASS_IN,
                                      dnsa_pkg::A_DATA_LEN, 1'b1);
                    4: put_record(dnsa_pkg::TYPE_A, 16'($urandom_range(2, 16'hFFFF)),
                                  dnsa_pkg::A_DATA_LEN, 1'b1);
                    5: put_record(dnsa_pkg::TYPE_A, dnsa_pkg::CLASS_IN,
                                  16'($urandom_range(6)), 1'b1);
                    6: put_record(16'h001C, dnsa_pkg::CLASS_IN, 16'h0010, 1'b1);
                    7: put_record(16'h0005, dnsa_pkg::CLASS_IN,
                                  16'($urandom_range(10)), 1'b1);
                    8: put_record(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                                  16'($urandom_range(8)), 1'b1);
                    default: put_record(16'($urandom_range(16'hFFFF)), dnsa_pkg::CLASS_IN,
                                        16'($urandom_range(20, 60)), 1'b1);
                endcase
            end
            if ($urandom_range(9) == 0)
                reply_bytes = reply_bytes[0:$urandom_range(reply_bytes.size() - 1)];
            else if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 8))
                    reply_bytes.push_back(rnd8());
        end
        random_bytes += reply_bytes.size();
        send_reply();
    endtask

    task automatic run_random_phase(input logic [15:0] id, input int idle_pct,
                                    input int stall_pct, input int nbytes);
        int stop_at;
        set_txn_id(id);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = random_bytes + nbytes;
        while (random_bytes < stop_at)
            random_reply();
    endtask

    task automatic test_random_traffic();
        run_random_phase(16'h0000, 0, 0, 70);
        run_random_phase(16'($urandom_range(16'hFFFF)), 75, 0, 70);
        run_random_phase(16'hFFFF, 0, 75, 70);
        run_random_phase(16'($urandom_range(16'hFFFF)), 13, 13, 70);
    endtask

    // Output side back-pressure.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each reply word with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: reply with none expected, status %0d address %08h",
                         $time, m_axis_tdata[2:0], m_axis_tdata[34:3]);
                failures++;
            end
            else
            begin
                oldest_reply = pending_replies.pop_front();
                if (m_axis_tdata[2:0] !== oldest_reply.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest_reply.status, m_axis_tdata[2:0]);
                    failures++;
                end
                if (m_axis_tdata[34:3] !== oldest_reply.address)
                begin
                    $display("%0t: address expected %08h actual %08h",
                             $time, oldest_reply.address, m_axis_tdata[34:3]);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        txn_id = 16'h0000;
        clear_parse();
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_header_checks();
        test_record_walk();
        test_name_skipping();
        test_message_limits();
        test_random_traffic();
        drain();
        if (pending_replies.size() != 0)
            failures++;
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
